@@ rtl/core/sfd_pkg.sv @@
// Shared package for the serial frame deframer.
// Holds the framing byte codes, the result codes, the result record and queue status.
// Has no dependencies; every other file of the deframer imports it.
`default_nettype none

package sfd_pkg;

  // Preamble and type codes on the serial link.
  localparam logic [7:0] PRE0_BYTE     = 8'hA1;
  localparam logic [7:0] PRE1_BYTE     = 8'hB2;
  localparam logic [7:0] PRE2_BYTE     = 8'hC3;
  localparam logic [7:0] TYPE_IMG_BYTE = 8'hAA;
  localparam logic [7:0] TYPE_LOC_BYTE = 8'hBB;
  localparam logic [7:0] TYPE_CMD_BYTE = 8'hCC;

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 10;

  // Reset values of the length registers.
  localparam logic [LEN_W-1:0] IMG_LEN_RST = 10'd482;
  localparam logic [LEN_W-1:0] LOC_LEN_RST = 10'd19;
  localparam logic [LEN_W-1:0] CMD_LEN_RST = 10'd1;

  // Default depth of the queue between the parser and the output stage.
  localparam int unsigned QDEPTH_DEF = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IMG_LEN = 2'd0,
    CFG_LOC_LEN = 2'd1,
    CFG_CMD_LEN = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_CSUM = 2'd2,
    KIND_BAD_TYPE = 2'd3
  } kind_t;

  // Frame types.
  localparam logic [1:0] FTYPE_IMG = 2'd0;
  localparam logic [1:0] FTYPE_LOC = 2'd1;
  localparam logic [1:0] FTYPE_CMD = 2'd2;

  // One result record as it travels through the queue.
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  byte_index;
    logic [1:0]        frame_type;
    logic              last;
  } result_t;

  // Queue status seen by the top level and the output stage.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/serial_frame_deframer.sv @@
// Top level of the preamble-framed serial deframer with XOR checksum.
// Instantiates sfd_front, sfd_queue and sfd_back; depends on sfd_pkg.
//
//   Channel | Direction | Signals                                    | Carries
//   in      | sink      | in_tvalid  in_tready  in_tdata[7:0]        | rx_byte
//   out     | source    | out_tvalid out_tready out_tdata/tuser/tlast | one result
//   cfg     | sink      | cfg_valid  cfg_ready  cfg_index cfg_data   | length register
//
// One byte is accepted per cycle while the queue is not full; the parser decides each
// byte in the cycle it arrives. A result passes into the queue and then into the output
// register before it reaches out_tvalid. Reset is synchronous on rst_n and clears all
// control state and the length registers to their defaults. Backpressure on out fills
// the QDEPTH-entry queue and then drops in_tready; cfg_ready is always high.
`default_nettype none

module serial_frame_deframer
  import sfd_pkg::*;
#(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // rx_byte [7:0]
  input  wire logic [7:0]        in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // data_byte [7:0], byte_index [17:8], frame_type [19:18], zero [23:20]
  output logic [23:0]            out_tdata,
  // kind [1:0]
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [LEN_W-1:0]  cfg_data
);

  logic    byte_acc;
  logic    q_push, q_pop;
  result_t f_res, q_head;
  q_stat_t q_stat;

  // Accept a byte whenever the queue has room for its possible result.
  assign in_tready = !q_stat.full;
  assign byte_acc  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_idx_t'(cfg_index)),
    .cfg_len   (cfg_data),
    .res       (f_res),
    .res_valid (q_push)
  );

  sfd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_res),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .stat       (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A result is only written into a queue with room.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("result pushed into a full queue");

  // A pushed result leaves the queue non-empty or is already in the output register.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (!q_stat.empty || out_tvalid))
    else $error("pushed result lost");

  // Payload results never close a frame; closing results carry index zero.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == KIND_PAYLOAD) == !out_tlast)
                   && (!out_tlast || out_tdata[17:8] == '0))
    else $error("inconsistent last flag on result");

  // Nothing is shown on the output right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

@@ rtl/core/sfd_front.sv @@
// Parser front end: preamble hunt, type decode, payload count and checksum check.
// Holds the length registers. Depends on sfd_pkg.
`default_nettype none

module sfd_front
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_acc,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic              cfg_we,
  input  wire cfg_idx_t          cfg_idx,
  input  wire logic [LEN_W-1:0]  cfg_len,
  output result_t                res,
  output logic                   res_valid
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_PRE1    = 3'd1,
    PH_PRE2    = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CSUM    = 3'd5
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         ftype_r, ftype_nxt;
  logic [LEN_W-1:0]   exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [BYTE_W-1:0]  xor_r, xor_nxt;
  logic [LEN_W-1:0]   img_len_r, loc_len_r, cmd_len_r;
  logic [LEN_W-1:0]   count_inc;

  assign count_inc = count_r + 1'b1;

  // Classify the incoming byte against the current phase.
  always_comb begin
    phase_nxt   = phase_r;
    ftype_nxt   = ftype_r;
    exp_len_nxt = exp_len_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    res         = '{kind: KIND_PAYLOAD, data_byte: rx_byte, byte_index: '0,
                    frame_type: '0, last: 1'b0};
    res_valid   = 1'b0;
    unique case (phase_r)
      PH_PRE1: phase_nxt = (rx_byte == PRE1_BYTE) ? PH_PRE2 : PH_HUNT;
      PH_PRE2: phase_nxt = (rx_byte == PRE2_BYTE) ? PH_TYPE : PH_HUNT;
      PH_TYPE: begin
        count_nxt = '0;
        xor_nxt   = rx_byte;
        priority if (rx_byte == TYPE_IMG_BYTE) begin
          ftype_nxt   = FTYPE_IMG;
          exp_len_nxt = img_len_r;
        end else if (rx_byte == TYPE_LOC_BYTE) begin
          ftype_nxt   = FTYPE_LOC;
          exp_len_nxt = loc_len_r;
        end else if (rx_byte == TYPE_CMD_BYTE) begin
          ftype_nxt   = FTYPE_CMD;
          exp_len_nxt = cmd_len_r;
        end else begin
          // Unknown type ends the attempt; the counters stay as they were.
          count_nxt = count_r;
          xor_nxt   = xor_r;
          res.kind  = KIND_BAD_TYPE;
          res.last  = 1'b1;
          res_valid = 1'b1;
        end
        if (!res_valid) begin
          phase_nxt = (exp_len_nxt == '0) ? PH_CSUM : PH_PAYLOAD;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        res.byte_index = count_r;
        res.frame_type = ftype_r;
        res_valid      = 1'b1;
        xor_nxt        = xor_r ^ rx_byte;
        count_nxt      = count_inc;
        if (count_inc >= exp_len_r) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        res.kind       = (rx_byte == xor_r) ? KIND_GOOD : KIND_BAD_CSUM;
        res.frame_type = ftype_r;
        res.last       = 1'b1;
        res_valid      = 1'b1;
        phase_nxt      = PH_HUNT;
      end
      default: phase_nxt = (rx_byte == PRE0_BYTE) ? PH_PRE1 : PH_HUNT;
    endcase
    if (!byte_acc) begin
      res_valid = 1'b0;
    end
  end

  // Frame state advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      ftype_r   <= '0;
      exp_len_r <= '0;
      count_r   <= '0;
      xor_r     <= '0;
    end else if (byte_acc) begin
      phase_r   <= phase_nxt;
      ftype_r   <= ftype_nxt;
      exp_len_r <= exp_len_nxt;
      count_r   <= count_nxt;
      xor_r     <= xor_nxt;
    end
  end

  // Length registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_len_r <= IMG_LEN_RST;
      loc_len_r <= LOC_LEN_RST;
      cmd_len_r <= CMD_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMG_LEN: img_len_r <= cfg_len;
        CFG_LOC_LEN: loc_len_r <= cfg_len;
        CFG_CMD_LEN: cmd_len_r <= cfg_len;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sfd_queue.sv @@
// Short result queue between the parser and the output stage.
// Register-based circular buffer with a fill count. Depends on sfd_pkg.
`default_nettype none

module sfd_queue
  import sfd_pkg::*;
#(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output result_t      head,
  output q_stat_t      stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sfd_back.sv @@
// Output stage: pulls results from the queue into the stream output register.
// Packs the result record into tdata, tuser and tlast. Depends on sfd_pkg.
`default_nettype none

module sfd_back
  import sfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire result_t head,
  input  wire q_stat_t stat,
  output logic         pop,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  // data_byte [7:0], byte_index [17:8], frame_type [19:18], zero [23:20]
  output logic [23:0]  out_tdata,
  // kind [1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  logic    vld_r;
  result_t res_r;

  // Load whenever the register is empty or its transaction completes.
  assign pop = !stat.empty && (!vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || out_tready) begin
      vld_r <= !stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {4'b0000, res_r.frame_type, res_r.byte_index, res_r.data_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

`default_nettype wire
